[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define ASSERT_NEXT(label, pre, post, msg) \
  `ASSERT_CLK(label, (pre) |=> (post), msg)

`endif

[rtl/spk_pkg.sv]
// Types and constants shared by the Speck32/64 encrypt unit.
package spk_pkg;

  localparam int unsigned WordW        = 16;
  localparam int unsigned NumRoundsDef = 22;
  localparam int unsigned CfgIdxW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyK0 = 2'd0,
    CfgKeyL0 = 2'd1,
    CfgKeyL1 = 2'd2,
    CfgKeyL2 = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] plaintext_right;
    logic [WordW-1:0] plaintext_left;
  } in_word_t;

  typedef struct packed {
    logic [WordW-1:0] ciphertext_right;
    logic [WordW-1:0] ciphertext_left;
  } out_word_t;

  // Block halves plus the running key schedule (round key and 3-word queue).
  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] rk;
    logic [WordW-1:0] l0;
    logic [WordW-1:0] l1;
    logic [WordW-1:0] l2;
  } spk_stage_t;

endpackage

[rtl/spk_round_stage.sv]
// One registered Speck round: data round and key schedule step.
module spk_round_stage #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  spk_pkg::spk_stage_t state_i,
  output logic                valid_o,
  output spk_pkg::spk_stage_t state_o
);
  import spk_pkg::*;

  function automatic logic [WordW-1:0] rotr7(input logic [WordW-1:0] v);
    return {v[6:0], v[WordW-1:7]};
  endfunction

  function automatic logic [WordW-1:0] rotl2(input logic [WordW-1:0] v);
    return {v[WordW-3:0], v[WordW-1:WordW-2]};
  endfunction

  logic             valid_q, valid_d;
  spk_stage_t       state_q, state_d;
  logic [WordW-1:0] new_l;

  always_comb begin
    state_d    = state_i;
    state_d.y  = (rotr7(state_i.y) + state_i.x) ^ state_i.rk;
    state_d.x  = rotl2(state_i.x) ^ state_d.y;
    // schedule: oldest queue word feeds this round, new word joins the tail
    new_l      = (rotr7(state_i.l0) + state_i.rk) ^ WordW'(RoundIdx);
    state_d.rk = rotl2(state_i.rk) ^ new_l;
    state_d.l0 = state_i.l1;
    state_d.l1 = state_i.l2;
    state_d.l2 = new_l;
  end

  assign valid_d = en_i ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

[rtl/speck32_64_encrypt_unit.sv]
// Top level of the Speck32/64 encrypt unit: key registers and round pipeline.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one plaintext word (two
//   16-bit halves). A word is taken on a clock edge with valid high and stall
//   low. Output channel: out_valid_o / out_stall_i carry the ciphertext word.
//   The user loads key words through cfg_we_i / cfg_index_i / cfg_data_i (index
//   0 = k0, 1..3 = l0..l2) only while no word is in flight; the block does not check it.
// Pipeline: one register stage per round between input acceptance and
//   out_valid_o; the last stage register drives the outputs.
// Throughput: one word per cycle unless the output stalls. Round keys travel
//   with each word, so every stage holds one round adder and one schedule adder.
// Stall: the whole pipeline holds while the output word is valid and
//   stalled; in_stall_o is raised in that same cycle, so nothing is lost or
//   repeated. Empty slots are not squeezed out during a hold.
// Reset: asynchronous, active low; clears all valid bits and the key words
//   to zero. No clearing pass is needed.
module speck32_64_encrypt_unit #(
  parameter int unsigned NUM_ROUNDS = spk_pkg::NumRoundsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  spk_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output spk_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_we_i,
  input  logic [spk_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [spk_pkg::WordW-1:0]           cfg_data_i
);
  import spk_pkg::*;
  `include "assert_macros.svh"

  // key words
  logic [WordW-1:0] key_k0_q, key_l0_q, key_l1_q, key_l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_k0_q <= '0;
      key_l0_q <= '0;
      key_l1_q <= '0;
      key_l2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgKeyK0: key_k0_q <= cfg_data_i;
        CfgKeyL0: key_l0_q <= cfg_data_i;
        CfgKeyL1: key_l1_q <= cfg_data_i;
        CfgKeyL2: key_l2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline: index 0 is the input, index k the output of round k-1
  logic [NUM_ROUNDS:0] vld;
  spk_stage_t          st [NUM_ROUNDS+1];
  logic                adv;

  // global hold while a finished word waits at the output
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign vld[0]   = in_valid_i;
  assign st[0].x  = in_word_i.plaintext_right;
  assign st[0].y  = in_word_i.plaintext_left;
  assign st[0].rk = key_k0_q;
  assign st[0].l0 = key_l0_q;
  assign st[0].l1 = key_l1_q;
  assign st[0].l2 = key_l2_q;

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    spk_round_stage #(
      .RoundIdx (r)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld[r]),
      .state_i (st[r]),
      .valid_o (vld[r+1]),
      .state_o (st[r+1])
    );
  end

  assign out_valid_o                 = vld[NUM_ROUNDS];
  assign out_word_o.ciphertext_right = st[NUM_ROUNDS].x;
  assign out_word_o.ciphertext_left  = st[NUM_ROUNDS].y;

  // a held pipeline keeps every slot as it was
  `ASSERT_NEXT(a_hold_keeps_valids, !adv, $stable(vld[NUM_ROUNDS:1]),
               "valid bits moved during a stall")

  // words in flight: one leaves at the output, one may enter at the input
  `ASSERT_NEXT(a_word_count, adv,
               $countones(vld[NUM_ROUNDS:1]) + $past(vld[NUM_ROUNDS]) ==
               $past($countones(vld[NUM_ROUNDS:1])) + $past(in_valid_i),
               "word lost or duplicated in the pipeline")

  // stall only ever comes from a blocked output word
  `ASSERT_CLK(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i),
              "input stalled without a blocked output")

endmodule

[tb/sv/tb_top.sv]
// Testbench for the Speck32/64 encrypt unit: directed, random-key, backpressure, drain-pause and full-rate tests.
`timescale 1ns / 100ps

module tb_top;
  import spk_pkg::*;

  localparam int unsigned NUM_ROUNDS = NumRoundsDef;
  // Cycles with no word moving on either side before the run is called hung.
  // The longest honest gap is the long receiver hold below plus a few key writes.
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 150;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  in_word_t            in_word     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  out_word_t           out_word;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [WordW-1:0]    cfg_data    = '0;

  // Key words as the block should hold them, indexed by register.
  logic [WordW-1:0]    key_word [4] = '{default: '0};
  // Ciphertext words predicted for accepted plaintext, oldest first.
  out_word_t           cipher_expect_q [$];
  out_word_t           cipher_head;
  int unsigned         mismatch_count = 0;

  // Idle control shared by the test tasks and the receiver stall process.
  bit                  tx_idle_on = 1'b0;
  bit                  rx_idle_on = 1'b0;
  int unsigned         rx_hold_req = 0;

  speck32_64_encrypt_unit #(
    .NUM_ROUNDS(NUM_ROUNDS)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Speck32/64: x is the right half, y the left half. The round key is
  // expanded alongside the rounds from k0 and the three schedule words.
  function automatic out_word_t speck_encrypt(input in_word_t plain);
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] rk;
    logic [WordW-1:0] nl;
    logic [WordW-1:0] sched [3];
    int unsigned      slot;
    out_word_t        cipher;
    x         = plain.plaintext_right;
    y         = plain.plaintext_left;
    rk        = key_word[CfgKeyK0];
    sched[0]  = key_word[CfgKeyL0];
    sched[1]  = key_word[CfgKeyL1];
    sched[2]  = key_word[CfgKeyL2];
    for (int unsigned r = 0; r < NUM_ROUNDS; r++) begin
      slot = r % 3;
      y = ({y[6:0], y[15:7]} + x) ^ rk;
      x = {x[13:0], x[15:14]} ^ y;
      // schedule word: same round function with the round index as key
      nl = ({sched[slot][6:0], sched[slot][15:7]} + rk) ^ r[WordW-1:0];
      sched[slot] = nl;
      rk = {rk[13:0], rk[15:14]} ^ nl;
    end
    cipher.ciphertext_right = x;
    cipher.ciphertext_left  = y;
    return cipher;
  endfunction

  // Random half word, biased toward the extremes now and then.
  function automatic logic [WordW-1:0] rand_half();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return WordW'($urandom);
  endfunction

  // Writes all four key registers on consecutive edges. Only called when idle.
  task automatic load_key(input logic [WordW-1:0] k0, input logic [WordW-1:0] l0,
                          input logic [WordW-1:0] l1, input logic [WordW-1:0] l2);
    logic [WordW-1:0] val [4];
    cfg_reg_e         reg_sel;
    val[CfgKeyK0] = k0;
    val[CfgKeyL0] = l0;
    val[CfgKeyL1] = l1;
    val[CfgKeyL2] = l2;
    reg_sel = reg_sel.first();
    repeat (reg_sel.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_sel;
      cfg_data  <= val[reg_sel];
      @(posedge clk);
      key_word[reg_sel] = val[reg_sel];
      reg_sel = reg_sel.next();
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one plaintext word, with an optional gap first, and books the
  // expected ciphertext once the word is taken. Valid stays high afterwards
  // so back-to-back calls run at full rate.
  task automatic send_block(input in_word_t plain);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= plain;
    do @(posedge clk); while (in_stall !== 1'b0);
    cipher_expect_q.push_back(speck_encrypt(plain));
  endtask

  task automatic send_random(input int unsigned count);
    in_word_t plain;
    repeat (count) begin
      plain.plaintext_right = rand_half();
      plain.plaintext_left  = rand_half();
      send_block(plain);
    end
  endtask

  // Drops valid and waits for every booked ciphertext word to come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic pick_idle_mode();
    int unsigned mode;
    mode = $urandom_range(0, 3);
    tx_idle_on = mode[0];
    rx_idle_on = mode[1];
  endtask

  // Extremes of both halves under the reset key, the published test vector
  // (expected ciphertext a868 42f2), and extremes under an all-ones key.
  task automatic test_directed();
    in_word_t plain;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_block('{plaintext_right: 16'h0000, plaintext_left: 16'h0000});
    send_block('{plaintext_right: 16'hFFFF, plaintext_left: 16'hFFFF});
    send_block('{plaintext_right: 16'h0000, plaintext_left: 16'hFFFF});
    send_block('{plaintext_right: 16'hFFFF, plaintext_left: 16'h0000});
    send_block('{plaintext_right: 16'hAAAA, plaintext_left: 16'h5555});
    drain();
    load_key(16'h0100, 16'h0908, 16'h1110, 16'h1918);
    send_block('{plaintext_right: 16'h694C, plaintext_left: 16'h6574});
    send_block('{plaintext_right: 16'h5555, plaintext_left: 16'hAAAA});
    send_block('{plaintext_right: 16'h0001, plaintext_left: 16'h8000});
    drain();
    load_key(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_block('{plaintext_right: 16'h0000, plaintext_left: 16'h0000});
    send_block('{plaintext_right: 16'hFFFF, plaintext_left: 16'hFFFF});
    send_block('{plaintext_right: 16'h8000, plaintext_left: 16'h0001});
    drain();
    // one key word at a time away from zero
    load_key(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    plain = '{plaintext_right: 16'h1234, plaintext_left: 16'hFEDC};
    send_block(plain);
    drain();
    load_key(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_block(plain);
    drain();
  endtask

  // Several key settings, extremes first, random traffic with idling mixed in.
  task automatic test_random_keys();
    for (int unsigned phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          load_key('1, '1, '1, '1);
        end
        1: begin
          load_key('0, '0, '0, '0);
        end
        default: begin
          load_key(rand_half(), rand_half(), rand_half(), rand_half());
        end
      endcase
      pick_idle_mode();
      send_random(200);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and the input stall must come up.
  task automatic test_backpressure();
    drain();
    load_key(rand_half(), rand_half(), rand_half(), rand_half());
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = LONG_HOLD;
    send_random(80);
  endtask

  // Sender stops mid-stream until every result is back, then resumes.
  task automatic test_drain_pause();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(30);
    drain();
    send_random(30);
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    drain();
    load_key(rand_half(), rand_half(), rand_half(), rand_half());
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(400);
  endtask

  // Receiver side: random stall bursts, or one long hold when asked.
  initial begin : rx_stall_gen
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result check: sampled at the edge, so both sides see pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_expect_q.size() == 0) begin
        $display("%0t: unexpected ciphertext word, expected none, got %h %h",
                 $time, out_word.ciphertext_right, out_word.ciphertext_left);
        mismatch_count++;
      end else begin
        cipher_head = cipher_expect_q.pop_front();
        if (out_word.ciphertext_right !== cipher_head.ciphertext_right) begin
          $display("%0t: ciphertext_right mismatch, expected %h, got %h",
                   $time, cipher_head.ciphertext_right, out_word.ciphertext_right);
          mismatch_count++;
        end
        if (out_word.ciphertext_left !== cipher_head.ciphertext_left) begin
          $display("%0t: ciphertext_left mismatch, expected %h, got %h",
                   $time, cipher_head.ciphertext_left, out_word.ciphertext_left);
          mismatch_count++;
        end
      end
    end
  end

  // Hang guard: counts edges at which no word moves on either channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : main_seq
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_keys();
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    drain();
    // let any stray word surface before the verdict
    repeat (NUM_ROUNDS + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
